[rtl/sdaf_pkg.sv]
// Package for the signed decimal ASCII formatter.
// Holds the sequencer state type, character codes and the reciprocal of ten.
// No dependencies.
`default_nettype none

package sdaf_pkg;

  // Widths of the datapath.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned PROD_W   = 2 * VALUE_W;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned IDX_W    = 4;

  // Quotient by ten is the product with this constant, shifted right by QUOT_SHIFT.
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned        QUOT_SHIFT = 35;
  localparam int unsigned        QUOT_W     = PROD_W - QUOT_SHIFT;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[rtl/signed_decimal_ascii_formatter_top.sv]
// Top level of the signed decimal ASCII formatter.
// Depends on sdaf_pkg for the state type, character codes and reciprocal of ten.
`default_nettype none

// Prints one signed 32-bit value as decimal ASCII on out_char_byte, marked by
// out_valid, with out_last_char on the final digit; the digits come one per
// cycle. A request is taken when start is high and busy is low; busy stays high
// until the last character has been issued. The receiver cannot stall: every
// character is shown for exactly one cycle. The sequencer first loads the
// magnitude into the shared 32x32 reciprocal multiplier in ST_MUL, then each digit
// costs one pass through that multiplier in ST_DIV (one quotient and remainder by
// ten per cycle), and then each digit is read back out in ST_EMIT, most
// significant first. The '-' of a negative value is issued in ST_MUL, ahead of
// the digit passes. Each character appears in the cycle after the sequencer
// produces it, through the output register.
module signed_decimal_ascii_formatter_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [sdaf_pkg::VALUE_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [sdaf_pkg::CHAR_W-1:0]            out_char_byte,
  output logic                                   out_last_char
);

  sdaf_pkg::state_t state_r, state_nxt;

  logic [sdaf_pkg::VALUE_W-1:0] mag_r, mag_nxt;
  logic [sdaf_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic                         neg_r, neg_nxt;
  logic [sdaf_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [sdaf_pkg::IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [sdaf_pkg::DIGIT_W-1:0] dig_r [sdaf_pkg::NUM_DIGITS];

  logic                         out_valid_r, out_valid_nxt;
  logic [sdaf_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic [sdaf_pkg::VALUE_W-1:0] in_bits;
  logic [sdaf_pkg::VALUE_W-1:0] quot;
  logic [sdaf_pkg::VALUE_W-1:0] quot_x10;
  logic [sdaf_pkg::VALUE_W-1:0] rem_full;
  logic [sdaf_pkg::DIGIT_W-1:0] rem_digit;
  logic [sdaf_pkg::VALUE_W-1:0] mul_a;
  logic [sdaf_pkg::PROD_W-1:0]  mul_p;
  logic                         div_done;
  logic                         dig_we;

  assign accept  = start && !busy;
  assign in_bits = in_value;

  // Quotient and remainder of the current dividend from the registered product.
  assign quot      = sdaf_pkg::VALUE_W'(prod_r[sdaf_pkg::PROD_W-1:sdaf_pkg::QUOT_SHIFT]);
  assign quot_x10  = (quot << 3) + (quot << 1);
  assign rem_full  = mag_r - quot_x10;
  assign rem_digit = rem_full[sdaf_pkg::DIGIT_W-1:0];
  assign div_done  = (quot == '0) ||
                     (cnt_r == sdaf_pkg::IDX_W'(sdaf_pkg::NUM_DIGITS - 1));

  // The shared multiplier takes the magnitude on load and the quotient afterwards.
  assign mul_a = (state_r == sdaf_pkg::ST_MUL) ? mag_r : quot;
  assign mul_p = sdaf_pkg::PROD_W'(mul_a) * sdaf_pkg::PROD_W'(sdaf_pkg::RECIP_TEN);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdaf_pkg::ST_IDLE: begin
        if (accept) state_nxt = sdaf_pkg::ST_MUL;
      end
      sdaf_pkg::ST_MUL: begin
        state_nxt = sdaf_pkg::ST_DIV;
      end
      sdaf_pkg::ST_DIV: begin
        if (div_done) state_nxt = sdaf_pkg::ST_EMIT;
      end
      sdaf_pkg::ST_EMIT: begin
        if (ptr_r == '0) state_nxt = sdaf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sdaf_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath updates and output characters for each state.
  always_comb begin
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    dig_we        = 1'b0;
    busy          = 1'b1;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    case (state_r)
      sdaf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          neg_nxt = in_bits[sdaf_pkg::VALUE_W-1];
          mag_nxt = in_bits[sdaf_pkg::VALUE_W-1] ? ('0 - in_bits) : in_bits;
          cnt_nxt = '0;
        end
      end
      sdaf_pkg::ST_MUL: begin
        prod_nxt = mul_p;
        if (neg_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sdaf_pkg::ASCII_MINUS;
        end
      end
      sdaf_pkg::ST_DIV: begin
        dig_we   = 1'b1;
        mag_nxt  = quot;
        prod_nxt = mul_p;
        cnt_nxt  = cnt_r + 1'b1;
        ptr_nxt  = cnt_r;
      end
      sdaf_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sdaf_pkg::ASCII_ZERO +
                        sdaf_pkg::CHAR_W'(dig_r[ptr_r]);
        out_last_nxt  = (ptr_r == '0);
        ptr_nxt       = ptr_r - 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer, written least significant digit first.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[cnt_r] <= rem_digit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_byte = out_char_r;
  assign out_last_char = out_last_r;

endmodule

`default_nettype wire

[rtl/sdaf_checker.sv]
// Port-level checker for the signed decimal ASCII formatter.
// Depends on sdaf_pkg for character codes; bound to signed_decimal_ascii_formatter_top.
`default_nettype none

module sdaf_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic [sdaf_pkg::CHAR_W-1:0]  out_char_byte,
  input wire logic                         out_last_char
);

  // A taken request keeps the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  // Every character is a minus sign or a decimal digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_byte == sdaf_pkg::ASCII_MINUS) ||
                  ((out_char_byte >= sdaf_pkg::ASCII_ZERO) &&
                   (out_char_byte <= sdaf_pkg::ASCII_ZERO + 8'd9)))
    else $error("character outside the decimal alphabet");

  // The minus sign never ends a number.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_byte == sdaf_pkg::ASCII_MINUS)) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  // A finished number is never directly followed by another character.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |=> !out_valid)
    else $error("character issued right after the last one");

  // Characters only follow a cycle in which the block was busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("character issued without a request in progress");

endmodule

bind signed_decimal_ascii_formatter_top sdaf_checker u_sdaf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_char_byte (out_char_byte),
  .out_last_char (out_last_char)
);

`default_nettype wire
